// ===== src/i2c_byte_level_master_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef I2C_BYTE_LEVEL_MASTER_CORE_MACROS_SVH
`define I2C_BYTE_LEVEL_MASTER_CORE_MACROS_SVH

// Check an implication on the rising clock, quiet while reset is asserted.
`define IBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds on the rising clock.
`define IBM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Check a condition in the cycle after the antecedent.
`define IBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ibm_pkg.sv =====
`default_nettype none

package ibm_pkg;

    // Command codes carried by each tick
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_WACK  = 3'd4,
        OP_READ  = 3'd5,
        OP_ACK   = 3'd6,
        OP_NACK  = 3'd7
    } op_t;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST1      = 4'd1,
        PH_ST2      = 4'd2,
        PH_SP1      = 4'd3,
        PH_SP2      = 4'd4,
        PH_WR_HI    = 4'd5,
        PH_WR_LO    = 4'd6,
        PH_WR_NEXT  = 4'd7,
        PH_AK_RISE  = 4'd8,
        PH_AK_POLL  = 4'd9,
        PH_AK_STOP1 = 4'd10,
        PH_AK_STOP2 = 4'd11,
        PH_RD_RISE  = 4'd12,
        PH_RD_NEXT  = 4'd13,
        PH_AN_HI    = 4'd14,
        PH_AN_LO    = 4'd15
    } phase_t;

    // Configuration register indexes
    localparam logic CFG_UNIT_TICKS  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] UNIT_TICKS_RST  = 16'd32;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

    // Delay lengths as shift amounts of the unit
    localparam logic [1:0] WAIT_1U = 2'd0;
    localparam logic [1:0] WAIT_2U = 2'd1;
    localparam logic [1:0] WAIT_4U = 2'd2;

    localparam int DELAY_W = 19;

    typedef struct packed {
        logic [15:0] unit;
        logic [7:0]  timeout;
    } cfg_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic       ready;
        logic       done;
        logic [7:0] rx;
        logic       miss;
    } res_t;

    // Load value of the delay counter for 1, 2 or 4 units
    function automatic logic [DELAY_W-1:0] wait_load(logic [1:0] sh, logic [15:0] unit);
        logic [DELAY_W-1:0] ext;
        ext = {3'b000, unit} << sh;
        return ext - {{(DELAY_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

// ===== src/ibm_cfg.sv =====
`default_nettype none

module ibm_cfg
    import ibm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    output cfg_t             cfg
);

    logic [15:0] unit_ticks_reg;
    logic [7:0]  ack_timeout_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg  <= UNIT_TICKS_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNIT_TICKS:  unit_ticks_reg  <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Treat a zero unit as one tick
    always_comb
    begin
        cfg.unit    = (unit_ticks_reg == 16'd0) ? 16'd1 : unit_ticks_reg;
        cfg.timeout = ack_timeout_reg;
    end

endmodule

`default_nettype wire

// ===== src/ibm_engine.sv =====
`default_nettype none

module ibm_engine
    import ibm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire cfg_t       cfg,
    input  wire op_t        opcode,
    input  wire logic [7:0] tx_byte,
    input  wire logic       sda_in,
    output res_t            res
);

    phase_t             phase_reg, phase_next;
    logic [3:0]         bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [7:0]         poll_reg, poll_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               drive_reg, drive_next;
    logic [7:0]         rx_reg, rx_next;
    logic               miss_reg, miss_next;

    // Hold sequencer state between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            delay_reg <= '0;
            poll_reg  <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drive_reg <= 1'b1;
            rx_reg    <= 8'd0;
            miss_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drive_reg <= drive_next;
            rx_reg    <= rx_next;
            miss_reg  <= miss_next;
        end
    end

    // Advance the sequence by one tick
    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drive_next = drive_reg;
        rx_next    = rx_reg;
        miss_next  = miss_reg;
        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                unique case (opcode)
                    OP_NONE: ;
                    OP_START:
                    begin
                        drive_next = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        delay_next = wait_load(WAIT_4U, cfg.unit);
                        phase_next = PH_ST1;
                    end
                    OP_STOP:
                    begin
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        delay_next = wait_load(WAIT_4U, cfg.unit);
                        phase_next = PH_SP1;
                    end
                    OP_WRITE:
                    begin
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = tx_byte[7];
                        shift_next = {tx_byte[6:0], 1'b0};
                        bit_next   = 4'd1;
                        delay_next = wait_load(WAIT_2U, cfg.unit);
                        phase_next = PH_WR_HI;
                    end
                    OP_WACK:
                    begin
                        drive_next = 1'b0;
                        poll_next  = 8'd0;
                        delay_next = wait_load(WAIT_1U, cfg.unit);
                        phase_next = PH_AK_RISE;
                    end
                    OP_READ:
                    begin
                        drive_next = 1'b0;
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                        scl_next   = 1'b0;
                        delay_next = wait_load(WAIT_2U, cfg.unit);
                        phase_next = PH_RD_RISE;
                    end
                    OP_ACK, OP_NACK:
                    begin
                        scl_next   = 1'b0;
                        drive_next = 1'b1;
                        sda_next   = (opcode == OP_NACK);
                        delay_next = wait_load(WAIT_2U, cfg.unit);
                        phase_next = PH_AN_HI;
                    end
                    default: ;
                endcase
            end
            else if (delay_reg != '0)
            begin
                delay_next = delay_reg - {{(DELAY_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                unique case (phase_reg)
                    PH_ST1:
                    begin
                        sda_next   = 1'b0;
                        delay_next = wait_load(WAIT_4U, cfg.unit);
                        phase_next = PH_ST2;
                    end
                    PH_ST2:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                    end
                    PH_SP1, PH_AK_STOP1:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        delay_next = wait_load(WAIT_4U, cfg.unit);
                        phase_next = (phase_reg == PH_SP1) ? PH_SP2 : PH_AK_STOP2;
                    end
                    PH_SP2:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_WR_HI:
                    begin
                        scl_next   = 1'b1;
                        delay_next = wait_load(WAIT_2U, cfg.unit);
                        phase_next = PH_WR_LO;
                    end
                    PH_WR_LO:
                    begin
                        scl_next   = 1'b0;
                        delay_next = wait_load(WAIT_2U, cfg.unit);
                        phase_next = PH_WR_NEXT;
                    end
                    PH_WR_NEXT:
                    begin
                        if (bit_reg < 4'd8)
                        begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            bit_next   = bit_reg + 4'd1;
                            delay_next = wait_load(WAIT_2U, cfg.unit);
                            phase_next = PH_WR_HI;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_AK_RISE:
                    begin
                        scl_next   = 1'b1;
                        delay_next = wait_load(WAIT_1U, cfg.unit);
                        phase_next = PH_AK_POLL;
                    end
                    PH_AK_POLL:
                    begin
                        if (!sda_in)
                        begin
                            scl_next   = 1'b0;
                            miss_next  = 1'b0;
                            phase_next = PH_IDLE;
                        end
                        else if (poll_reg >= cfg.timeout)
                        begin
                            drive_next = 1'b1;
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            delay_next = wait_load(WAIT_4U, cfg.unit);
                            phase_next = PH_AK_STOP1;
                        end
                        else
                        begin
                            poll_next = poll_reg + 8'd1;
                        end
                    end
                    PH_AK_STOP2:
                    begin
                        miss_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    PH_RD_RISE:
                    begin
                        scl_next   = 1'b1;
                        shift_next = {shift_reg[6:0], sda_in};
                        bit_next   = bit_reg + 4'd1;
                        delay_next = wait_load(WAIT_1U, cfg.unit);
                        phase_next = PH_RD_NEXT;
                    end
                    PH_RD_NEXT:
                    begin
                        if (bit_reg < 4'd8)
                        begin
                            scl_next   = 1'b0;
                            delay_next = wait_load(WAIT_2U, cfg.unit);
                            phase_next = PH_RD_RISE;
                        end
                        else
                        begin
                            rx_next    = shift_reg;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_AN_HI:
                    begin
                        scl_next   = 1'b1;
                        delay_next = wait_load(WAIT_2U, cfg.unit);
                        phase_next = PH_AN_LO;
                    end
                    PH_AN_LO:
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Report line levels after this tick and the accept and finish pulses
    always_comb
    begin
        res.scl   = scl_next;
        res.sda   = sda_next;
        res.drive = drive_next;
        res.ready = step && (phase_reg == PH_IDLE) && (opcode != OP_NONE);
        res.done  = step && (phase_reg != PH_IDLE) && (delay_reg == '0)
                    && (phase_next == PH_IDLE);
        res.rx    = rx_next;
        res.miss  = miss_next;
    end

endmodule

`default_nettype wire

// ===== src/i2c_byte_level_master_core.sv =====
`default_nettype none

// Byte-level I2C master. Each transfer on the cmd channel is one tick of the
// bit timer and yields exactly one transfer on the res channel with the SCL/SDA
// levels after that tick. A tick is taken every clock cycle when the result
// side keeps up; its result passes from the input register through one pass of
// the sequencer logic into the result register, and is offered on the res
// channel from there. A stalled result holds the input register,
// which drops cmd_ready until the result moves. Line delays are counted in
// ticks, so a start or stop spans 8*unit_ticks+1 ticks and a byte write
// 48*unit_ticks+1 ticks, whatever the clock rate of ticks. Write the
// configuration registers only while no tick is in flight.
module i2c_byte_level_master_core
    import ibm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        sda_in,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic             scl_level,
    output logic             sda_level,
    output logic             sda_drive,
    output logic             ready_res,
    output logic             done_res,
    output logic [7:0]       rx_byte,
    output logic             ack_missing
);

    cfg_t       cfg;
    res_t       res_comb;
    res_t       res_reg;
    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [7:0] tx_reg;
    logic       sda_in_reg;
    logic       res_valid_reg;
    logic       advance;

    ibm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move a tick forward when the result register is free or draining
    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || advance;

    // Capture the incoming transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            op_reg     <= opcode;
            tx_reg     <= tx_byte;
            sda_in_reg <= sda_in;
        end
    end

    ibm_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .cfg     (cfg),
        .opcode  (op_t'(op_reg)),
        .tx_byte (tx_reg),
        .sda_in  (sda_in_reg),
        .res     (res_comb)
    );

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || res_ready)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign res_valid   = res_valid_reg;
    assign scl_level   = res_reg.scl;
    assign sda_level   = res_reg.sda;
    assign sda_drive   = res_reg.drive;
    assign ready_res   = res_reg.ready;
    assign done_res    = res_reg.done;
    assign rx_byte     = res_reg.rx;
    assign ack_missing = res_reg.miss;

endmodule

`default_nettype wire

// ===== src/ibm_checker.sv =====
`default_nettype none

`include "i2c_byte_level_master_core_macros.svh"

module ibm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_valid,
    input wire logic        cmd_ready,
    input wire logic [2:0]  opcode,
    input wire logic [7:0]  tx_byte,
    input wire logic        sda_in,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        scl_level,
    input wire logic        sda_level,
    input wire logic        sda_drive,
    input wire logic        ready_res,
    input wire logic        done_res,
    input wire logic [7:0]  rx_byte,
    input wire logic        ack_missing
);

    logic [13:0] res_fields;
    logic [11:0] cmd_fields;

    assign res_fields = {scl_level, sda_level, sda_drive, ready_res, done_res, rx_byte,
                         ack_missing};
    assign cmd_fields = {opcode, tx_byte, sda_in};

    // A stalled result keeps its fields
    `IBM_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
                     res_valid && $stable(res_fields), "stalled result changed")

    // A waiting command keeps its fields
    `IBM_ASSERT_NEXT(a_cmd_hold, clk, rst_n, cmd_valid && !cmd_ready,
                     cmd_valid && $stable(cmd_fields), "waiting transfer changed")

    // A tick cannot both start and finish a command
    `IBM_ASSERT_NEVER(a_ready_done, clk, rst_n, res_valid && ready_res && done_res, "accept and finish in one tick")

    // With the result register empty a new transfer is always taken
    `IBM_ASSERT_IMPL(a_empty_ready, clk, rst_n, !res_valid, cmd_ready, "input stalled while output empty")

endmodule

bind i2c_byte_level_master_core ibm_checker u_ibm_checker (.*);

`default_nettype wire
